>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ILHA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define ILHA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> rtl/ilha_pkg.sv
// Types and constants of the boundary-tag heap allocator.
package ilha_pkg;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam logic [16:0] EXTEND_RESET = 17'd4096;
  localparam logic [16:0] MIN_CHUNK    = 17'd16;

  // Init image: pad, prologue header, prologue footer, epilogue.
  localparam logic [31:0] PAD_WORD  = 32'h0000_0000;
  localparam logic [31:0] PRO_WORD  = 32'h0000_0009;
  localparam logic [31:0] EPI_WORD  = 32'h0000_0001;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] request_size;
    logic [15:0] block_addr;
  } cmd_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_WR, S_FF_RD, S_FF_CHK, S_GROW_CHK, S_GROW_WR,
    S_MG_RD0, S_MG_RD1, S_MG_EVAL, S_MG_WR, S_PUT_WR,
    S_RL_RD, S_RL_CHK, S_RL_WR, S_DONE
  } eng_state_t;

endpackage

>>> rtl/ilha_ram.sv
// Heap word memory: one write port, one registered read port.
module ilha_ram import ilha_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int IW    = 14
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [31:0]   wr_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/ilha_engine.sv
// Allocator sequencer: list walks, heap growth, coalescing and splitting.
module ilha_engine import ilha_pkg::*; #(
  parameter int HEAP_BYTES = 65536,
  parameter int XW         = 18,
  parameter int IW         = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  input  logic [16:0]   chunk,
  output logic          rsp_valid,
  input  logic          rsp_take,
  output rsp_t          rsp,
  output logic          rd_en,
  output logic [IW-1:0] rd_idx,
  input  logic [31:0]   rd_data,
  output logic          wr_en,
  output logic [IW-1:0] wr_idx,
  output logic [31:0]   wr_data
);

  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] C4     = XW'(4);
  localparam logic [XW-1:0] C8     = XW'(8);
  localparam logic [XW-1:0] C16    = XW'(16);

  eng_state_t    state_r, state_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic [XW-1:0] asize_r, asize_nxt;
  logic [XW-1:0] bp_r, bp_nxt;
  logic [XW-1:0] size_r, size_nxt;
  logic [XW-1:0] psize_r, psize_nxt;
  logic          pu_r, pu_nxt;
  logic [XW-1:0] brk_r, brk_nxt;
  logic          ready_r, ready_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [15:0]   res_r, res_nxt;

  logic [XW-1:0] hdr_size;
  logic          hdr_used;
  logic [16:0]   req_sum;
  logic [16:0]   req_round;
  logic [XW-1:0] asize_calc;
  logic [XW-1:0] chunk_x;
  logic [XW-1:0] gbytes;
  logic [XW-3:0] gw;
  logic [XW-1:0] gsize;
  logic [XW-1:0] gend;
  logic          gfit;
  logic [XW-1:0] rem;
  logic          split;
  logic [XW-1:0] psz;
  logic          ff_hit;
  logic          at_end;
  logic [XW-1:0] bp_step;
  logic          addr_hit;
  logic [XW-1:0] mg_base;
  logic [XW-1:0] mg_tot;
  eng_state_t    post_merge;
  logic [XW-1:0] rd_ba;
  logic [XW-1:0] wr_ba;

  assign hdr_size   = {rd_data[XW-1:3], 3'b000};
  assign hdr_used   = rd_data[0];
  assign req_sum    = {1'b0, cmd.request_size} + 17'd15;
  assign req_round  = (cmd.request_size <= 16'd8) ? 17'd16 : {req_sum[16:3], 3'b000};
  assign asize_calc = XW'(req_round);
  assign chunk_x    = XW'(chunk);
  assign gbytes     = (asize_r > chunk_x) ? asize_r : chunk_x;
  assign gw         = gbytes[XW-1:2] + (XW-2)'(1);
  assign gsize      = {gw[XW-3:1], 3'b000};
  assign gend       = brk_r + gsize;
  assign gfit       = gend <= HEAP_X;
  assign rem        = size_r - asize_r;
  assign split      = rem >= C16;
  assign psz        = split ? asize_r : size_r;
  assign ff_hit     = !hdr_used && (asize_r <= hdr_size);
  assign at_end     = bp_r >= brk_r;
  assign bp_step    = bp_r + hdr_size;
  assign addr_hit   = bp_r == XW'(addr_r);
  assign mg_base    = pu_r ? bp_r : bp_r - psize_r;
  assign mg_tot     = size_r + (pu_r ? '0 : psize_r) + (hdr_used ? '0 : hdr_size);
  assign post_merge = (op_r == MODE_ALLOC) ? S_PUT_WR : S_DONE;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.mode)
            MODE_INIT:  state_nxt = S_INIT_WR;
            MODE_ALLOC: state_nxt = (cmd.request_size == '0 || !ready_r) ? S_DONE : S_FF_RD;
            MODE_FREE:  state_nxt = ready_r ? S_RL_RD : S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT_WR: begin
        if (cnt_r == 2'd3) state_nxt = S_GROW_CHK;
        else cnt_nxt = cnt_r + 2'd1;
      end
      S_FF_RD:    state_nxt = at_end ? S_GROW_CHK : S_FF_CHK;
      S_FF_CHK: begin
        if (hdr_size == '0) state_nxt = S_GROW_CHK;
        else if (ff_hit) state_nxt = S_PUT_WR;
        else state_nxt = S_FF_RD;
      end
      S_GROW_CHK: state_nxt = gfit ? S_GROW_WR : S_DONE;
      S_GROW_WR: begin
        if (cnt_r == 2'd2) state_nxt = S_MG_RD0;
        else cnt_nxt = cnt_r + 2'd1;
      end
      S_MG_RD0:   state_nxt = S_MG_RD1;
      S_MG_RD1:   state_nxt = S_MG_EVAL;
      S_MG_EVAL:  state_nxt = (pu_r && hdr_used) ? post_merge : S_MG_WR;
      S_MG_WR: begin
        if (cnt_r == 2'd1) state_nxt = post_merge;
        else cnt_nxt = cnt_r + 2'd1;
      end
      S_PUT_WR: begin
        if ((cnt_r == 2'd1 && !split) || cnt_r == 2'd3) state_nxt = S_DONE;
        else cnt_nxt = cnt_r + 2'd1;
      end
      S_RL_RD:    state_nxt = at_end ? S_DONE : S_RL_CHK;
      S_RL_CHK: begin
        if (hdr_size == '0) state_nxt = S_DONE;
        else if (addr_hit) state_nxt = hdr_used ? S_RL_WR : S_DONE;
        else state_nxt = S_RL_RD;
      end
      S_RL_WR: begin
        if (cnt_r == 2'd1) state_nxt = S_MG_RD0;
        else cnt_nxt = cnt_r + 2'd1;
      end
      S_DONE:     state_nxt = rsp_take ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    rd_en     = 1'b0;
    rd_ba     = bp_r - C4;
    wr_en     = 1'b0;
    wr_ba     = bp_r - C4;
    wr_data   = 32'(size_r);
    cmd_ready = 1'b0;
    rsp_valid = 1'b0;
    unique case (state_r)
      S_IDLE: cmd_ready = 1'b1;
      S_INIT_WR: begin
        wr_en = 1'b1;
        wr_ba = XW'({cnt_r, 2'b00});
        case (cnt_r)
          2'd0:    wr_data = PAD_WORD;
          2'd3:    wr_data = EPI_WORD;
          default: wr_data = PRO_WORD;
        endcase
      end
      S_FF_RD, S_RL_RD: rd_en = !at_end;
      S_GROW_WR: begin
        wr_en = 1'b1;
        case (cnt_r)
          2'd0:    wr_ba = bp_r - C4;
          2'd1:    wr_ba = bp_r + size_r - C8;
          default: begin
            wr_ba   = bp_r + size_r - C4;
            wr_data = EPI_WORD;
          end
        endcase
      end
      S_MG_RD0: begin
        rd_en = 1'b1;
        rd_ba = bp_r - C8;
      end
      S_MG_RD1: begin
        rd_en = 1'b1;
        rd_ba = bp_r + size_r - C4;
      end
      S_MG_WR, S_RL_WR: begin
        wr_en = 1'b1;
        wr_ba = (cnt_r == 2'd0) ? bp_r - C4 : bp_r + size_r - C8;
      end
      S_PUT_WR: begin
        wr_en = 1'b1;
        case (cnt_r)
          2'd0: begin
            wr_ba   = bp_r - C4;
            wr_data = 32'(psz) | 32'd1;
          end
          2'd1: begin
            wr_ba   = bp_r + psz - C8;
            wr_data = 32'(psz) | 32'd1;
          end
          2'd2: begin
            wr_ba   = bp_r + asize_r - C4;
            wr_data = 32'(rem);
          end
          default: begin
            wr_ba   = bp_r + size_r - C8;
            wr_data = 32'(rem);
          end
        endcase
      end
      S_DONE: rsp_valid = 1'b1;
      default: ;
    endcase
  end

  assign rd_idx = rd_ba[IW+1:2];
  assign wr_idx = wr_ba[IW+1:2];

  // Datapath register updates.
  always_comb begin
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    asize_nxt  = asize_r;
    bp_nxt     = bp_r;
    size_nxt   = size_r;
    psize_nxt  = psize_r;
    pu_nxt     = pu_r;
    brk_nxt    = brk_r;
    ready_nxt  = ready_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt     = cmd.mode;
          addr_nxt   = cmd.block_addr;
          status_nxt = ST_OK;
          res_nxt    = '0;
          asize_nxt  = asize_calc;
          bp_nxt     = (cmd.mode == MODE_FREE) ? C16 : C8;
          if (cmd.mode == MODE_ALLOC) begin
            if (cmd.request_size == '0) status_nxt = ST_ZERO;
            else if (!ready_r) status_nxt = ST_OOM;
          end
        end
      end
      S_INIT_WR: begin
        if (cnt_r == 2'd3) begin
          brk_nxt   = C16;
          ready_nxt = 1'b1;
          asize_nxt = '0;
        end
      end
      S_FF_CHK: begin
        if (hdr_size != '0) begin
          if (ff_hit) size_nxt = hdr_size;
          else bp_nxt = bp_step;
        end
      end
      S_GROW_CHK: begin
        if (!gfit) begin
          status_nxt = ST_OOM;
        end else begin
          bp_nxt   = brk_r;
          size_nxt = gsize;
          brk_nxt  = gend;
        end
      end
      S_MG_RD1: begin
        psize_nxt = hdr_size;
        pu_nxt    = hdr_used;
      end
      S_MG_EVAL: begin
        bp_nxt   = mg_base;
        size_nxt = mg_tot;
      end
      S_PUT_WR: res_nxt = bp_r[15:0];
      S_RL_CHK: begin
        if (hdr_size != '0) begin
          if (addr_hit) size_nxt = hdr_size;
          else bp_nxt = bp_step;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      brk_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      brk_r   <= brk_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    asize_r  <= asize_nxt;
    bp_r     <= bp_nxt;
    size_r   <= size_nxt;
    psize_r  <= psize_nxt;
    pu_r     <= pu_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign rsp.result_addr = res_r;
  assign rsp.status      = status_r;

endmodule

>>> rtl/implicit_list_heap_allocator.sv
// Top level of the boundary-tag heap allocator.
//
// Usage: each transfer on the in_ stream is one command (init, allocate,
// free); each command returns exactly one transfer on the out_ stream with
// the payload offset of the new block (allocate) and a status code.
// cfg_wr_en/cfg_wr_data set the minimum heap extension in bytes; write it
// only while no command is in flight.
// Init writes the pad, prologue and epilogue words and grows the heap by
// the extension. Allocate walks block headers first fit and marks a found
// block, splitting off a rest of 16 bytes or more; else it grows the heap,
// coalesces and splits, or reports out of memory; a zero size or a command
// before init goes straight to the result. Free walks the headers to a
// used target, clears it and coalesces with free neighbours. Throughput:
// one command at a time; the next transfers once the previous result is in
// the output register, so the header walk and heap fragmentation set the rate.
// Reset: the heap is not ready (allocate answers out of memory until an
// init), the break is zero, the extension is 4096 bytes; memory is not
// cleared and no word is read before it is written.
// Stall: the result sits in an output register; the block takes the next
// command while it waits and holds the following result until it drains.
module implicit_list_heap_allocator import ilha_pkg::*; #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,  // extend_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // mode[1:0], request_size[17:2], block_addr[33:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata     // result_addr[15:0], status[17:16]
);

  // Byte offsets must hold the break plus the largest extension.
  localparam int XW    = $clog2(HEAP_BYTES + 65544) + 1;
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int IW    = $clog2(DEPTH);

  logic [16:0]   extend_r;
  logic [16:0]   chunk;
  cmd_t          cmd;
  rsp_t          rsp;
  logic          rsp_valid;
  logic          rsp_take;
  logic          out_valid_r;
  rsp_t          out_data_r;
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_data;

  // Extension size register; saturate up to one minimum block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extend_r <= EXTEND_RESET;
    end else if (cfg_wr_en) begin
      extend_r <= cfg_wr_data;
    end
  end

  assign chunk = (extend_r < MIN_CHUNK) ? MIN_CHUNK : extend_r;

  // Unpack the command transfer.
  assign cmd.mode         = in_tdata[1:0];
  assign cmd.request_size = in_tdata[17:2];
  assign cmd.block_addr   = in_tdata[33:18];

  ilha_engine #(
    .HEAP_BYTES (HEAP_BYTES),
    .XW         (XW),
    .IW         (IW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd       (cmd),
    .chunk     (chunk),
    .rsp_valid (rsp_valid),
    .rsp_take  (rsp_take),
    .rsp       (rsp),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data)
  );

  ilha_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  // Advance a finished result into the output register when it is free
  // or draining this cycle; otherwise hold the engine in its done state.
  assign rsp_take = rsp_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_data_r.status, out_data_r.result_addr};

endmodule

>>> rtl/ilha_chk.sv
// Port-level checker for the heap allocator, bound to the top level.
`include "assert_macros.svh"

module ilha_chk import ilha_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result stays offered.
  `ILHA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // One command at a time: the engine is busy right after a transfer.
  `ILHA_ASSERT_NXT(a_busy_after_cmd, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Ready drops only because a command was taken.
  `ILHA_ASSERT_IMP(a_ready_fall, clk, rst_n, $fell(in_tready), $past(in_tvalid && in_tready))

  // Refused or failed commands carry no block offset.
  `ILHA_ASSERT_IMP(a_fail_no_addr, clk, rst_n, out_tvalid && out_tdata[17:16] != ST_OK, out_tdata[15:0] == 16'h0000)

endmodule

bind implicit_list_heap_allocator ilha_chk u_ilha_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
